// File: rtl/rrbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rrbm_pkg;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 22;
    localparam int BANK_W   = 7;
    localparam int SRAM_W   = 8;
    localparam int ROM_OFS_W  = 14;
    localparam int SRAM_OFS_W = 13;

    typedef logic [1:0] t_cmd;

    localparam t_cmd CMD_WRITE    = 2'd0;
    localparam t_cmd CMD_MAP_ROM  = 2'd1;
    localparam t_cmd CMD_MAP_SRAM = 2'd2;

    typedef logic [2:0] t_region;

    localparam t_region REGION_RAM_EN   = 3'd0;
    localparam t_region REGION_ROM_BANK = 3'd1;
    localparam t_region REGION_UPPER    = 3'd2;
    localparam t_region REGION_MODE     = 3'd3;

    localparam logic [3:0]        RAM_EN_KEY     = 4'hA;
    localparam logic [BANK_W-1:0] UPPER_BANK_RST = 7'd1;

    typedef struct packed {
        logic              ram_en;
        logic [BANK_W-1:0] upper_bank;
        logic [BANK_W-1:0] lower_bank;
        logic [SRAM_W-1:0] sram_bank;
        logic              mode;
    } t_bank_state;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_wr_req;

endpackage

`default_nettype wire

// File: rtl/rrbm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface rrbm_in_if;
    logic                       valid;
    logic                       ready;
    rrbm_pkg::t_cmd             cmd;
    logic [rrbm_pkg::ADDR_W-1:0] bus_address;
    logic [rrbm_pkg::DATA_W-1:0] write_data;

    modport source (output valid, output cmd, output bus_address, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input bus_address, input write_data,
                    output ready);
endinterface

interface rrbm_out_if;
    logic                       valid;
    logic                       ready;
    logic [rrbm_pkg::MAP_W-1:0] mapped_address;
    logic                       ram_on;

    modport source (output valid, output mapped_address, output ram_on, input ready);
    modport sink   (input valid, input mapped_address, input ram_on, output ready);
endinterface

`default_nettype wire

// File: rtl/rrbm_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbm_regs (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  rrbm_pkg::t_wr_req     i_wr,
    output rrbm_pkg::t_bank_state o_state,
    output logic                  o_ram_on_next
);

    rrbm_pkg::t_bank_state r_state;
    rrbm_pkg::t_bank_state n_state;
    logic [4:0]            w_low_bits;
    logic [1:0]            w_hi_bits;

    assign w_low_bits = (i_wr.data[4:0] == 5'd0) ? 5'd1 : i_wr.data[4:0];
    assign w_hi_bits  = i_wr.data[1:0];

    always_comb begin
        n_state = r_state;
        if (i_wr.en) begin
            unique case (i_wr.addr[15:13])
                rrbm_pkg::REGION_RAM_EN: begin
                    n_state.ram_en = (i_wr.data[3:0] == rrbm_pkg::RAM_EN_KEY);
                end
                rrbm_pkg::REGION_ROM_BANK: begin
                    n_state.upper_bank = {r_state.upper_bank[6:5], w_low_bits};
                end
                rrbm_pkg::REGION_UPPER: begin
                    if (r_state.mode) begin
                        n_state.lower_bank = {w_hi_bits, 5'd0};
                        n_state.upper_bank = {w_hi_bits, r_state.upper_bank[4:0]};
                    end else begin
                        n_state.sram_bank = i_wr.data;
                    end
                end
                rrbm_pkg::REGION_MODE: begin
                    n_state.mode = i_wr.data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ram_en     <= 1'b0;
            r_state.upper_bank <= rrbm_pkg::UPPER_BANK_RST;
            r_state.lower_bank <= '0;
            r_state.sram_bank  <= '0;
            r_state.mode       <= 1'b0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state       = r_state;
    assign o_ram_on_next = n_state.ram_en;

    a_upper_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.upper_bank[4:0] != 5'd0)
        else $error("ROM bank low bits are zero.");

    a_lower_low_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.lower_bank[4:0] == 5'd0)
        else $error("Lower area bank has low bits set.");

    a_sram_only_mode0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mode |=> (r_state.sram_bank == $past(r_state.sram_bank)))
        else $error("SRAM bank changed in banking mode 1.");

endmodule

`default_nettype wire

// File: rtl/rrbm_map.sv
`timescale 1ns / 1ps
`default_nettype none

module rrbm_map (
    input  rrbm_pkg::t_cmd                i_cmd,
    input  wire [rrbm_pkg::ADDR_W-1:0]    i_bus_address,
    input  rrbm_pkg::t_bank_state         i_state,
    output logic [rrbm_pkg::MAP_W-1:0]    o_mapped_address
);

    logic [rrbm_pkg::MAP_W-1:0] w_rom_addr;
    logic [rrbm_pkg::MAP_W-1:0] w_sram_addr;
    logic [rrbm_pkg::BANK_W-1:0] w_rom_bank;

    always_comb begin
        if (i_bus_address[15:14] == 2'd0) begin
            w_rom_bank = i_state.mode ? i_state.lower_bank : '0;
        end else begin
            w_rom_bank = i_state.upper_bank;
        end
    end

    assign w_rom_addr = {1'b0, w_rom_bank, i_bus_address[rrbm_pkg::ROM_OFS_W-1:0]};

    assign w_sram_addr = {1'b0, i_state.sram_bank, {rrbm_pkg::SRAM_OFS_W{1'b0}}}
                       + {6'd0, i_bus_address};

    always_comb begin
        unique case (i_cmd)
            rrbm_pkg::CMD_MAP_ROM:  o_mapped_address = w_rom_addr;
            rrbm_pkg::CMD_MAP_SRAM: o_mapped_address = w_sram_addr;
            default:                o_mapped_address = '0;
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rom_ram_bank_mapper_type1_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat
// i_in     in   cmd, bus_address, write_data
// o_out    out  mapped_address, ram_on
//
// Each beat passes an input register and a result register. Its result is offered once it
// has moved into the result register, and one beat is taken every cycle while the output is not stalled.
// The bank registers change as a write moves from the input to the result register.
// Reset clears both valid flags and returns the bank registers to their power-up values.
// A stalled output holds its beat, and the input register still takes a new beat
// whenever its current one can move on.

module rom_ram_bank_mapper_type1_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    rrbm_in_if.sink     i_in,
    rrbm_out_if.source  o_out
);

    logic                        r_in_valid;
    rrbm_pkg::t_cmd              r_in_cmd;
    logic [rrbm_pkg::ADDR_W-1:0] r_in_addr;
    logic [rrbm_pkg::DATA_W-1:0] r_in_data;

    logic                        r_out_valid;
    logic [rrbm_pkg::MAP_W-1:0]  r_out_mapped;
    logic                        r_out_ram_on;

    logic                        n_in_valid;
    logic                        n_out_valid;

    logic                        w_out_free;
    logic                        w_adv;
    logic                        w_take;
    rrbm_pkg::t_wr_req           w_wr;
    rrbm_pkg::t_bank_state       w_state;
    logic                        w_ram_on_next;
    logic [rrbm_pkg::MAP_W-1:0]  w_mapped;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && w_out_free;
    assign i_in.ready = !r_in_valid || w_out_free;
    assign w_take     = i_in.valid && i_in.ready;

    assign w_wr.en   = w_adv && (r_in_cmd == rrbm_pkg::CMD_WRITE);
    assign w_wr.addr = r_in_addr;
    assign w_wr.data = r_in_data;

    rrbm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (w_wr),
        .o_state       (w_state),
        .o_ram_on_next (w_ram_on_next)
    );

    rrbm_map u_map (
        .i_cmd            (r_in_cmd),
        .i_bus_address    (r_in_addr),
        .i_state          (w_state),
        .o_mapped_address (w_mapped)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_take) begin
            n_in_valid = 1'b1;
        end else if (w_adv) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_adv) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_cmd  <= i_in.cmd;
            r_in_addr <= i_in.bus_address;
            r_in_data <= i_in.write_data;
        end
        if (w_adv) begin
            r_out_mapped <= w_mapped;
            r_out_ram_on <= w_ram_on_next;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.mapped_address = r_out_mapped;
    assign o_out.ram_on         = r_out_ram_on;

    a_write_maps_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_cmd == rrbm_pkg::CMD_WRITE)) |=> (r_out_mapped == '0))
        else $error("A write produced a nonzero mapped address.");

    a_hold_blocked_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_free) |=> (r_in_valid && $stable(r_in_cmd)
                                         && $stable(r_in_addr)))
        else $error("Blocked input beat was lost or changed.");

    a_rom_fixed_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_cmd == rrbm_pkg::CMD_MAP_ROM) && (r_in_addr[15:14] == 2'd0)
         && !w_state.mode) |=> (r_out_mapped == {6'd0, $past(r_in_addr)}))
        else $error("Fixed ROM area did not map to itself in mode 0.");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import rrbm_pkg::*;

    localparam t_cmd CMD_UNUSED = 2'd3;

    typedef struct packed {
        t_cmd              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_bus_beat;

    typedef struct packed {
        logic [MAP_W-1:0] addr;
        logic             ram_on;
    } t_mapped_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rrbm_in_if  in_ch ();
    rrbm_out_if out_ch ();

    rom_ram_bank_mapper_type1_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always #5 i_clk = ~i_clk;

    t_bus_beat    pending_beats[$];
    t_mapped_beat expected_maps[$];
    t_bank_state  banks;
    t_bus_beat    next_beat;
    t_mapped_beat want;

    int beats_queued = 0;
    int beats_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic recv_hold = 1'b0;

    // Mirrors the bank registers and returns the address the cartridge would see.
    function automatic t_mapped_beat map_beat(t_cmd cmd, logic [ADDR_W-1:0] addr,
                                              logic [DATA_W-1:0] data);
        t_mapped_beat r;
        logic [MAP_W-1:0] base;
        logic [MAP_W-1:0] ofs;
        logic [4:0] lo;
        logic [1:0] d;
        r.addr = '0;
        ofs = MAP_W'(addr);
        case (cmd)
            CMD_WRITE: begin
                if (addr < 16'h2000) begin
                    banks.ram_en = (data[3:0] == RAM_EN_KEY);
                end else if (addr < 16'h4000) begin
                    lo = data[4:0];
                    if (lo == 5'd0) begin
                        lo = 5'd1;
                    end
                    banks.upper_bank[4:0] = lo;
                end else if (addr < 16'h6000) begin
                    if (banks.mode) begin
                        d = data[1:0];
                        banks.lower_bank = {d, 5'd0};
                        banks.upper_bank[6:5] = d;
                    end else begin
                        banks.sram_bank = data;
                    end
                end else if (addr < 16'h8000) begin
                    banks.mode = data[0];
                end
            end
            CMD_MAP_ROM: begin
                if (addr < 16'h4000) begin
                    base = MAP_W'(banks.lower_bank);
                    r.addr = banks.mode ? (ofs | (base << ROM_OFS_W)) : ofs;
                end else begin
                    base = MAP_W'(banks.upper_bank);
                    ofs = MAP_W'(addr[ROM_OFS_W-1:0]);
                    r.addr = ofs + (base << ROM_OFS_W);
                end
            end
            CMD_MAP_SRAM: begin
                base = MAP_W'(banks.sram_bank);
                r.addr = ofs + (base << SRAM_OFS_W);
            end
            default: begin
            end
        endcase
        r.ram_on = banks.ram_en;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [MAP_W-1:0] got, logic [MAP_W-1:0] exp_val);
        $display("mismatch at %0t ns: %s, got %h, expected %h", $time, what, got, exp_val);
        mismatch_count++;
    endtask

    task automatic push_beat(t_cmd cmd, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        t_bus_beat b;
        b.cmd = cmd;
        b.addr = addr;
        b.data = data;
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    // Register writes, mostly inside the four register windows, mixed with mapped ROM and SRAM reads,
    // with some writes above the windows and some unused commands mixed in.
    task automatic push_random(int n);
        int pick;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        t_cmd c;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            a = ADDR_W'($urandom);
            d = DATA_W'($urandom);
            if (pick < 40) begin
                c = CMD_WRITE;
                if (pick < 36) begin
                    a[15] = 1'b0;
                end
                if ($urandom_range(0, 3) == 0) begin
                    d[3:0] = RAM_EN_KEY;
                end
                if ($urandom_range(0, 7) == 0) begin
                    d[4:0] = 5'd0;
                end
            end else if (pick < 70) begin
                c = CMD_MAP_ROM;
                if ($urandom_range(0, 3) != 0) begin
                    a[15] = 1'b0;
                end
            end else if (pick < 95) begin
                c = CMD_MAP_SRAM;
            end else begin
                c = CMD_UNUSED;
            end
            push_beat(c, a, d);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_maps.push_back(map_beat(in_ch.cmd, in_ch.bus_address,
                                                 in_ch.write_data));
                beats_accepted <= beats_accepted + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_beat = pending_beats.pop_front();
                    in_ch.cmd <= next_beat.cmd;
                    in_ch.bus_address <= next_beat.addr;
                    in_ch.write_data <= next_beat.data;
                    in_ch.valid <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_seen <= results_seen + 1;
            if (expected_maps.size() == 0) begin
                report_mismatch("beat with nothing expected", out_ch.mapped_address, '0);
            end else begin
                want = expected_maps.pop_front();
                if (out_ch.mapped_address !== want.addr) begin
                    report_mismatch("mapped_address", out_ch.mapped_address, want.addr);
                end
                if (out_ch.ram_on !== want.ram_on) begin
                    report_mismatch("ram_on", MAP_W'(out_ch.ram_on), MAP_W'(want.ram_on));
                end
            end
        end
        out_ch.ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // The sender keeps offering beats while the output is held off, so the core backs up.
    initial begin
        wait (results_seen >= 40);
        @(posedge i_clk);
        recv_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        recv_hold <= 1'b0;
    end

    initial begin
        #2000000;
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_WRITE;
        in_ch.bus_address = '0;
        in_ch.write_data = '0;
        out_ch.ready = 1'b0;
        banks.ram_en = 1'b0;
        banks.upper_bank = UPPER_BANK_RST;
        banks.lower_bank = '0;
        banks.sram_bank = '0;
        banks.mode = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(CMD_MAP_ROM, 16'h0000, 8'h00);
        push_beat(CMD_MAP_ROM, 16'h3FFF, 8'h00);
        push_beat(CMD_MAP_ROM, 16'h4000, 8'h00);
        push_beat(CMD_MAP_ROM, 16'hFFFF, 8'hFF);
        push_beat(CMD_MAP_SRAM, 16'h0000, 8'h00);
        push_beat(CMD_MAP_SRAM, 16'hFFFF, 8'hFF);
        push_beat(CMD_WRITE, 16'h0000, 8'h0A);
        push_beat(CMD_WRITE, 16'h1FFF, 8'hFA);
        push_beat(CMD_WRITE, 16'h0100, 8'h0B);
        push_beat(CMD_WRITE, 16'h1234, 8'hFA);
        push_beat(CMD_WRITE, 16'h2000, 8'h00);
        push_beat(CMD_MAP_ROM, 16'h7FFF, 8'h00);
        push_beat(CMD_WRITE, 16'h3FFF, 8'hFF);
        push_beat(CMD_MAP_ROM, 16'h4000, 8'h00);
        push_beat(CMD_WRITE, 16'h4000, 8'hFF);
        push_beat(CMD_MAP_SRAM, 16'hFFFF, 8'h00);
        push_beat(CMD_WRITE, 16'h6000, 8'hFF);
        push_beat(CMD_WRITE, 16'h5FFF, 8'hFF);
        push_beat(CMD_MAP_ROM, 16'h0000, 8'h00);
        push_beat(CMD_MAP_ROM, 16'h3FFF, 8'h00);
        push_beat(CMD_MAP_ROM, 16'h7FFF, 8'h00);
        push_beat(CMD_WRITE, 16'h8000, 8'h00);
        push_beat(CMD_WRITE, 16'hFFFF, 8'hFF);
        push_beat(CMD_UNUSED, 16'hFFFF, 8'hFF);
        push_beat(CMD_WRITE, 16'h7FFF, 8'hFE);
        push_beat(CMD_MAP_ROM, 16'h1234, 8'h00);
        wait (beats_accepted == beats_queued);

        push_random(357);
        wait (beats_accepted == beats_queued);

        send_idle_pct <= 54;
        push_random(357);
        wait (beats_accepted == beats_queued);

        send_idle_pct <= 0;
        recv_stall_pct <= 54;
        push_random(357);
        wait (beats_accepted == beats_queued);

        send_idle_pct <= 21;
        recv_stall_pct <= 21;
        push_random(357);
        wait (beats_accepted == beats_queued);

        wait (results_seen == beats_accepted);
        repeat (8) @(posedge i_clk);
        if (expected_maps.size() != 0) begin
            report_mismatch("beats never delivered", '0, MAP_W'(expected_maps.size()));
        end
        if (mismatch_count == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
